>>> rtl/vtc_pkg.sv
// ----------------------------------------------------------------------------
// vtc_pkg
// Shared command codes, register indexes and the control and status
// structures that join the text cell controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vtc_pkg;

  // command kinds
  localparam logic [4:0] KIND_GLYPH   = 5'd0;
  localparam logic [4:0] KIND_MOVE    = 5'd1;
  localparam logic [4:0] KIND_FWD     = 5'd2;
  localparam logic [4:0] KIND_BACK    = 5'd3;
  localparam logic [4:0] KIND_UP      = 5'd4;
  localparam logic [4:0] KIND_DOWN    = 5'd5;
  localparam logic [4:0] KIND_CR      = 5'd6;
  localparam logic [4:0] KIND_LF      = 5'd7;
  localparam logic [4:0] KIND_RLF     = 5'd8;
  localparam logic [4:0] KIND_SCRLUP  = 5'd9;
  localparam logic [4:0] KIND_SCRLDN  = 5'd10;
  localparam logic [4:0] KIND_REGION  = 5'd11;
  localparam logic [4:0] KIND_ELINE   = 5'd12;
  localparam logic [4:0] KIND_EDISP   = 5'd13;
  localparam logic [4:0] KIND_INSL    = 5'd14;
  localparam logic [4:0] KIND_DELL    = 5'd15;
  localparam logic [4:0] KIND_INSC    = 5'd16;
  localparam logic [4:0] KIND_DELC    = 5'd17;
  localparam logic [4:0] KIND_SAVE    = 5'd18;
  localparam logic [4:0] KIND_RESTORE = 5'd19;
  localparam logic [4:0] KIND_CLEAR   = 5'd20;
  localparam logic [4:0] KIND_TICK    = 5'd21;
  localparam logic [4:0] KIND_READ    = 5'd22;

  // erase modes
  localparam logic [1:0] ERASE_TO_END   = 2'd0;
  localparam logic [1:0] ERASE_TO_START = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_COLS   = 2'd0;
  localparam logic [1:0] CFG_ROWS   = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;

  // reset values and constants
  localparam logic [7:0] COLS_DEFAULT  = 8'd80;
  localparam logic [6:0] ROWS_DEFAULT  = 7'd24;
  localparam logic [7:0] BLINK_DEFAULT = 8'd50;
  localparam logic [7:0] BLANK_CHAR    = 8'h20;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic plan;
    logic clear;
    logic load;
    logic sel;
    logic wr;
    logic adv;
    logic fin;
    logic report;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic reinit;
    logic en0;
    logic en1;
    logic copy;
    logic last;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/vtc_ram.sv
// ----------------------------------------------------------------------------
// vtc_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vtc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/vtc_ctrl.sv
// ----------------------------------------------------------------------------
// vtc_ctrl
// Sequencer for the text cell engine: takes a request, has the datapath
// plan it, walks up to two cell sweeps, then finishes and reports unless clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module vtc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire vtc_pkg::stat_t st,
  output vtc_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLRP  = 4'd1;
  localparam logic [3:0] S_PLAN  = 4'd2;
  localparam logic [3:0] S_LOAD0 = 4'd3;
  localparam logic [3:0] S_LOAD1 = 4'd4;
  localparam logic [3:0] S_CELL  = 4'd5;
  localparam logic [3:0] S_COPYW = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_REP   = 4'd8;

  logic [3:0] state, state_next;
  logic       clearing, clearing_next;
  logic       idx, idx_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd           = '0;
    state_next    = state;
    clearing_next = clearing;
    idx_next      = idx;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.take   = 1'b1;
          state_next = S_PLAN;
        end
      end
      S_CLRP: begin
        cmd.plan   = 1'b1;
        cmd.clear  = 1'b1;
        state_next = S_LOAD0;
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = S_LOAD0;
      end
      S_LOAD0: begin
        if (st.en0) begin
          cmd.load   = 1'b1;
          cmd.sel    = 1'b0;
          idx_next   = 1'b0;
          state_next = S_CELL;
        end else begin
          state_next = S_LOAD1;
        end
      end
      S_LOAD1: begin
        if (st.en1) begin
          cmd.load   = 1'b1;
          cmd.sel    = 1'b1;
          idx_next   = 1'b1;
          state_next = S_CELL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_CELL: begin
        if (st.copy) begin
          state_next = S_COPYW;
        end else begin
          cmd.wr  = 1'b1;
          cmd.adv = 1'b1;
          if (st.last) begin
            state_next = idx ? S_FIN : S_LOAD1;
          end
        end
      end
      S_COPYW: begin
        cmd.wr  = 1'b1;
        cmd.adv = 1'b1;
        if (st.last) begin
          state_next = idx ? S_FIN : S_LOAD1;
        end else begin
          state_next = S_CELL;
        end
      end
      S_FIN: begin
        if (clearing) begin
          clearing_next = 1'b0;
          state_next    = S_IDLE;
        end else begin
          cmd.fin    = 1'b1;
          state_next = S_REP;
        end
      end
      S_REP: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // dimension write restarts the clearing pass
    if (st.reinit) begin
      state_next    = S_CLRP;
      clearing_next = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLRP;
      clearing <= 1'b1;
      idx      <= 1'b0;
    end else begin
      state    <= state_next;
      clearing <= clearing_next;
      idx      <= idx_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vtc_dpath.sv
// ----------------------------------------------------------------------------
// vtc_dpath
// Datapath of the text cell engine: configuration, cursor and blink state,
// request planning into cell sweeps, sweep counters and the cell store.
// ----------------------------------------------------------------------------
`default_nettype none

module vtc_dpath #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire vtc_pkg::cmd_t        cmd,
  output vtc_pkg::stat_t            st,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic [4:0]           kind,
  input  wire logic [7:0]           glyph,
  input  wire logic                 inverse,
  input  wire logic [7:0]           count,
  input  wire logic signed [7:0]    column,
  input  wire logic signed [7:0]    row,
  input  wire logic signed [7:0]    bottom_row,
  input  wire logic [1:0]           erase_mode,
  output logic                      done,
  output logic [6:0]                cursor_column,
  output logic [5:0]                cursor_row,
  output logic                      wrap_pending,
  output logic                      cursor_visible,
  output logic [7:0]                cell_char,
  output logic                      cell_inverse
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_LINES);
  localparam int DEPTH = MAX_LINES * (2 ** CW);
  localparam logic [9:0] MAXC = 10'(MAX_COLUMNS);
  localparam logic [9:0] MAXR = 10'(MAX_LINES);
  localparam int ROWS0 = (int'(vtc_pkg::ROWS_DEFAULT) > MAX_LINES) ?
                         MAX_LINES : int'(vtc_pkg::ROWS_DEFAULT);
  localparam logic [RW-1:0] BOT0 = RW'(ROWS0 - 1);

  // one sweep: rows times cells, blank or copy from an offset cell
  typedef struct packed {
    logic       en;
    logic       copy;
    logic [9:0] row0;
    logic       rneg;
    logic [9:0] rcnt;
    logic [9:0] dy;
    logic [9:0] col0;
    logic       cneg;
    logic [9:0] ccnt;
    logic [9:0] dx;
  } sweep_t;

  typedef struct packed {
    sweep_t s0;
    sweep_t s1;
  } plan_t;

  function automatic sweep_t mk(input logic cp, input logic [9:0] r0, input logic rn,
                                input logic [9:0] rc, input logic [9:0] dyv,
                                input logic [9:0] c0, input logic cn,
                                input logic [9:0] cc0, input logic [9:0] dxv);
    sweep_t s;
    s.en   = (rc != 10'd0) && (cc0 != 10'd0);
    s.copy = cp;
    s.row0 = r0;
    s.rneg = rn;
    s.rcnt = rc;
    s.dy   = dyv;
    s.col0 = c0;
    s.cneg = cn;
    s.ccnt = cc0;
    s.dx   = dxv;
    return s;
  endfunction

  // region scroll as a row copy sweep and a blanking sweep, or a blanking sweep alone when the count covers the region
  function automatic plan_t scroll(input logic up, input logic [9:0] top,
                                   input logic [9:0] bot, input logic [9:0] n,
                                   input logic [9:0] w);
    plan_t      p;
    logic [9:0] span;
    p    = '0;
    span = bot - top + 10'd1;
    if (bot >= top) begin
      if (n >= span) begin
        p.s0 = mk(1'b0, top, 1'b0, span, 10'd0, 10'd0, 1'b0, w, 10'd0);
      end else if (up) begin
        p.s0 = mk(1'b1, top, 1'b0, span - n, n, 10'd0, 1'b0, w, 10'd0);
        p.s1 = mk(1'b0, bot - n + 10'd1, 1'b0, n, 10'd0, 10'd0, 1'b0, w, 10'd0);
      end else begin
        p.s0 = mk(1'b1, bot, 1'b1, span - n, 10'd0 - n, 10'd0, 1'b0, w, 10'd0);
        p.s1 = mk(1'b0, top, 1'b0, n, 10'd0, 10'd0, 1'b0, w, 10'd0);
      end
    end
    return p;
  endfunction

  function automatic logic [9:0] clamp_s(input logic [7:0] v, input logic [9:0] lim);
    logic [9:0] r;
    r = {2'b00, v};
    if (v[7]) begin
      r = 10'd0;
    end else if (r >= lim) begin
      r = lim - 10'd1;
    end
    return r;
  endfunction

  // configuration registers
  logic [7:0] act_cols;
  logic [6:0] act_rows;
  logic [7:0] blink_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_cols     <= vtc_pkg::COLS_DEFAULT;
      act_rows     <= vtc_pkg::ROWS_DEFAULT;
      blink_period <= vtc_pkg::BLINK_DEFAULT;
    end else if (cfg_write) begin
      case (cfg_index)
        vtc_pkg::CFG_COLS:   act_cols     <= cfg_data;
        vtc_pkg::CFG_ROWS:   act_rows     <= cfg_data[6:0];
        vtc_pkg::CFG_PERIOD: blink_period <= cfg_data;
        default: ;
      endcase
    end
  end

  assign st.reinit = cfg_write && (cfg_index inside {vtc_pkg::CFG_COLS, vtc_pkg::CFG_ROWS});

  logic [9:0] cols_w, rows_w;
  always_comb begin
    cols_w = {2'b00, act_cols};
    if (cols_w == 10'd0) cols_w = 10'd1;
    if (cols_w > MAXC) cols_w = MAXC;
    rows_w = {3'b000, act_rows};
    if (rows_w == 10'd0) rows_w = 10'd1;
    if (rows_w > MAXR) rows_w = MAXR;
  end

  // latched request
  logic [4:0] k_kind;
  logic [7:0] k_glyph;
  logic       k_inv;
  logic [7:0] k_count;
  logic [7:0] k_col, k_row, k_bot;
  logic [1:0] k_mode;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      k_kind  <= kind;
      k_glyph <= glyph;
      k_inv   <= inverse;
      k_count <= count;
      k_col   <= column;
      k_row   <= row;
      k_bot   <= bottom_row;
      k_mode  <= erase_mode;
    end
  end

  // engine state
  logic [CW-1:0] cur_col, saved_col, fcol;
  logic [RW-1:0] cur_row, saved_row, reg_top, reg_bot, frow;
  logic          hang, saved_hang, shown, phase;
  logic [7:0]    ticks;
  plan_t         plan;

  logic [9:0] col_next, row_next, scol_next, srow_next, top_next, bot_next;
  logic [9:0] fcol_next, frow_next;
  logic       hang_next, shang_next, shown_next, phase_next;
  logic [7:0] ticks_next;
  plan_t      plan_next;

  logic [9:0] cc, cr, tp, bt, nn, wc, wrow, rem, span_s, span_e;
  logic [7:0] period, t1;
  logic signed [10:0] rtop, rbot, rlast;

  // request planning and cursor update
  always_comb begin
    cc = 10'(cur_col);
    cr = 10'(cur_row);
    tp = 10'(reg_top);
    bt = 10'(reg_bot);
    nn = (k_count == 8'd0) ? 10'd1 : {2'b00, k_count};
    col_next   = cc;
    row_next   = cr;
    hang_next  = hang;
    scol_next  = 10'(saved_col);
    srow_next  = 10'(saved_row);
    shang_next = saved_hang;
    top_next   = tp;
    bot_next   = bt;
    shown_next = shown;
    phase_next = phase;
    ticks_next = ticks;
    plan_next  = '0;
    fcol_next  = cc;
    frow_next  = cr;
    wc     = hang ? 10'd0 : cc;
    wrow   = cr;
    rem    = cols_w - cc;
    span_s = (k_mode == vtc_pkg::ERASE_TO_END) ? cc : 10'd0;
    span_e = (k_mode == vtc_pkg::ERASE_TO_START) ? cc + 10'd1 : cols_w;
    period = (blink_period == 8'd0) ? 8'd1 : blink_period;
    t1     = (ticks != 8'd255) ? ticks + 8'd1 : ticks;
    rtop   = 11'(signed'(k_row));
    rbot   = 11'(signed'(k_bot));
    rlast  = signed'({1'b0, rows_w}) - 11'sd1;
    if (rbot <= 11'sd0) rbot = rlast;
    if (rtop < 11'sd0) rtop = 11'sd0;
    if (rtop > rlast) rtop = rlast;
    if (rbot > rlast) rbot = rlast;

    case (k_kind)
      vtc_pkg::KIND_GLYPH: begin
        if (hang) begin
          if (cr == bt) begin
            plan_next = scroll(1'b1, tp, bt, 10'd1, cols_w);
          end else if (cr + 10'd1 < rows_w) begin
            wrow = cr + 10'd1;
          end
        end
        fcol_next = wc;
        frow_next = wrow;
        row_next  = wrow;
        if (wc + 10'd1 >= cols_w) begin
          col_next  = wc;
          hang_next = 1'b1;
        end else begin
          col_next  = wc + 10'd1;
          hang_next = 1'b0;
        end
        phase_next = 1'b1; ticks_next = 8'd0; shown_next = 1'b1;
      end
      vtc_pkg::KIND_MOVE: begin
        col_next  = clamp_s(k_col, cols_w);
        row_next  = clamp_s(k_row, rows_w);
        hang_next = 1'b0;
        phase_next = 1'b1; ticks_next = 8'd0; shown_next = 1'b1;
      end
      vtc_pkg::KIND_FWD: begin
        if (hang) begin
          hang_next = 1'b0;
          col_next  = 10'd0;
          if (cr == bt) begin
            plan_next = scroll(1'b1, tp, bt, 10'd1, cols_w);
          end else if (cr + 10'd1 < rows_w) begin
            row_next = cr + 10'd1;
          end
          shown_next = 1'b1;
        end else if (cc + 10'd1 >= cols_w) begin
          hang_next = 1'b1;
        end else begin
          col_next   = cc + 10'd1;
          shown_next = 1'b1;
        end
      end
      vtc_pkg::KIND_BACK: begin
        if (hang) begin
          hang_next = 1'b0;
        end else if (cc != 10'd0) begin
          col_next   = cc - 10'd1;
          shown_next = 1'b1;
        end
      end
      vtc_pkg::KIND_UP: begin
        row_next   = (cr < tp + nn) ? tp : cr - nn;
        hang_next  = 1'b0;
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_DOWN: begin
        row_next   = (cr + nn > bt) ? bt : cr + nn;
        hang_next  = 1'b0;
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_CR: begin
        col_next = 10'd0; hang_next = 1'b0; shown_next = 1'b1;
      end
      vtc_pkg::KIND_LF: begin
        hang_next = 1'b0;
        if (cr == bt) begin
          plan_next = scroll(1'b1, tp, bt, 10'd1, cols_w);
        end else if (cr + 10'd1 < rows_w) begin
          row_next = cr + 10'd1;
        end
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_RLF: begin
        hang_next = 1'b0;
        if (cr == tp) begin
          plan_next = scroll(1'b0, tp, bt, 10'd1, cols_w);
        end else if (cr != 10'd0) begin
          row_next = cr - 10'd1;
        end
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_SCRLUP: begin
        plan_next  = scroll(1'b1, tp, bt, nn, cols_w);
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_SCRLDN: begin
        plan_next  = scroll(1'b0, tp, bt, nn, cols_w);
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_REGION: begin
        if (rtop < rbot) begin
          top_next  = 10'(rtop);
          bot_next  = 10'(rbot);
          col_next  = 10'd0;
          row_next  = 10'(rtop);
          hang_next = 1'b0;
          phase_next = 1'b1; ticks_next = 8'd0; shown_next = 1'b1;
        end
      end
      vtc_pkg::KIND_ELINE: begin
        plan_next.s0 = mk(1'b0, cr, 1'b0, 10'd1, 10'd0, span_s, 1'b0,
                          span_e - span_s, 10'd0);
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_EDISP: begin
        if (k_mode == vtc_pkg::ERASE_TO_END) begin
          plan_next.s0 = mk(1'b0, cr, 1'b0, 10'd1, 10'd0, cc, 1'b0, cols_w - cc, 10'd0);
          plan_next.s1 = mk(1'b0, cr + 10'd1, 1'b0, rows_w - cr - 10'd1, 10'd0,
                            10'd0, 1'b0, cols_w, 10'd0);
        end else if (k_mode == vtc_pkg::ERASE_TO_START) begin
          plan_next.s0 = mk(1'b0, cr, 1'b0, 10'd1, 10'd0, 10'd0, 1'b0, cc + 10'd1, 10'd0);
          plan_next.s1 = mk(1'b0, 10'd0, 1'b0, cr, 10'd0, 10'd0, 1'b0, cols_w, 10'd0);
        end else begin
          plan_next.s0 = mk(1'b0, 10'd0, 1'b0, rows_w, 10'd0, 10'd0, 1'b0, cols_w, 10'd0);
        end
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_INSL, vtc_pkg::KIND_DELL: begin
        if (cr >= tp && cr <= bt) begin
          plan_next  = scroll(k_kind == vtc_pkg::KIND_DELL, cr, bt, nn, cols_w);
          col_next   = 10'd0;
          hang_next  = 1'b0;
          shown_next = 1'b1;
        end
      end
      vtc_pkg::KIND_INSC, vtc_pkg::KIND_DELC: begin
        if (nn >= rem) begin
          plan_next.s0 = mk(1'b0, cr, 1'b0, 10'd1, 10'd0, cc, 1'b0, rem, 10'd0);
        end else if (k_kind == vtc_pkg::KIND_INSC) begin
          plan_next.s0 = mk(1'b1, cr, 1'b0, 10'd1, 10'd0, cols_w - 10'd1, 1'b1,
                            rem - nn, 10'd0 - nn);
          plan_next.s1 = mk(1'b0, cr, 1'b0, 10'd1, 10'd0, cc, 1'b0, nn, 10'd0);
        end else begin
          plan_next.s0 = mk(1'b1, cr, 1'b0, 10'd1, 10'd0, cc, 1'b0, rem - nn, nn);
          plan_next.s1 = mk(1'b0, cr, 1'b0, 10'd1, 10'd0, cols_w - nn, 1'b0, nn, 10'd0);
        end
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_SAVE: begin
        scol_next  = cc;
        srow_next  = cr;
        shang_next = hang;
      end
      vtc_pkg::KIND_RESTORE: begin
        col_next  = (10'(saved_col) >= cols_w) ? cols_w - 10'd1 : 10'(saved_col);
        row_next  = (10'(saved_row) >= rows_w) ? rows_w - 10'd1 : 10'(saved_row);
        hang_next = saved_hang;
        phase_next = 1'b1; ticks_next = 8'd0; shown_next = 1'b1;
      end
      vtc_pkg::KIND_CLEAR: begin
        plan_next.s0 = mk(1'b0, 10'd0, 1'b0, rows_w, 10'd0, 10'd0, 1'b0, cols_w, 10'd0);
        col_next   = 10'd0;
        row_next   = 10'd0;
        hang_next  = 1'b0;
        shown_next = 1'b1;
      end
      vtc_pkg::KIND_TICK: begin
        if (t1 >= period) begin
          ticks_next = 8'd0;
          phase_next = ~phase;
          shown_next = ~phase;
        end else begin
          ticks_next = t1;
        end
      end
      vtc_pkg::KIND_READ: begin
        fcol_next = clamp_s(k_col, cols_w);
        frow_next = clamp_s(k_row, rows_w);
      end
      default: ;
    endcase

    // clearing pass after reset or a dimension write
    if (cmd.clear) begin
      col_next   = 10'd0;
      row_next   = 10'd0;
      hang_next  = 1'b0;
      scol_next  = 10'd0;
      srow_next  = 10'd0;
      shang_next = 1'b0;
      top_next   = 10'd0;
      bot_next   = rows_w - 10'd1;
      shown_next = 1'b1;
      phase_next = 1'b1;
      ticks_next = 8'd0;
      plan_next  = '0;
      plan_next.s0 = mk(1'b0, 10'd0, 1'b0, rows_w, 10'd0, 10'd0, 1'b0, cols_w, 10'd0);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      hang       <= 1'b0;
      saved_col  <= '0;
      saved_row  <= '0;
      saved_hang <= 1'b0;
      reg_top    <= '0;
      reg_bot    <= BOT0;
      shown      <= 1'b1;
      phase      <= 1'b1;
      ticks      <= 8'd0;
      plan       <= '0;
    end else if (cmd.plan) begin
      cur_col    <= CW'(col_next);
      cur_row    <= RW'(row_next);
      hang       <= hang_next;
      saved_col  <= CW'(scol_next);
      saved_row  <= RW'(srow_next);
      saved_hang <= shang_next;
      reg_top    <= RW'(top_next);
      reg_bot    <= RW'(bot_next);
      shown      <= shown_next;
      phase      <= phase_next;
      ticks      <= ticks_next;
      plan       <= plan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      fcol <= CW'(fcol_next);
      frow <= RW'(frow_next);
    end
  end

  // sweep counters
  sweep_t     sw;
  logic [9:0] prow, pcol, rleft, cleft;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sw    <= cmd.sel ? plan.s1 : plan.s0;
      prow  <= cmd.sel ? plan.s1.row0 : plan.s0.row0;
      pcol  <= cmd.sel ? plan.s1.col0 : plan.s0.col0;
      rleft <= cmd.sel ? plan.s1.rcnt : plan.s0.rcnt;
      cleft <= cmd.sel ? plan.s1.ccnt : plan.s0.ccnt;
    end else if (cmd.adv) begin
      if (cleft != 10'd1) begin
        cleft <= cleft - 10'd1;
        pcol  <= sw.cneg ? pcol - 10'd1 : pcol + 10'd1;
      end else begin
        cleft <= sw.ccnt;
        pcol  <= sw.col0;
        rleft <= rleft - 10'd1;
        prow  <= sw.rneg ? prow - 10'd1 : prow + 10'd1;
      end
    end
  end

  assign st.en0  = plan.s0.en;
  assign st.en1  = plan.s1.en;
  assign st.copy = sw.copy;
  assign st.last = (cleft == 10'd1) && (rleft == 10'd1);

  // cell store access
  logic [9:0]          srow_w, scol_w;
  logic [RW+CW-1:0]    dst_addr, src_addr, fin_addr, waddr, raddr;
  logic [8:0]          wdata, rdata;
  logic                we, is_glyph, is_read;

  assign srow_w   = prow + sw.dy;
  assign scol_w   = pcol + sw.dx;
  assign dst_addr = {prow[RW-1:0], pcol[CW-1:0]};
  assign src_addr = {srow_w[RW-1:0], scol_w[CW-1:0]};
  assign fin_addr = {frow, fcol};
  assign is_glyph = (k_kind == vtc_pkg::KIND_GLYPH);
  assign is_read  = (k_kind == vtc_pkg::KIND_READ);

  assign we    = cmd.wr || (cmd.fin && is_glyph);
  assign waddr = cmd.fin ? fin_addr : dst_addr;
  assign raddr = cmd.fin ? fin_addr : src_addr;
  assign wdata = cmd.fin ? {k_inv, k_glyph} : (sw.copy ? rdata : {1'b0, vtc_pkg::BLANK_CHAR});

  vtc_ram #(
    .WIDTH (9),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      cursor_column  <= 7'(cur_col);
      cursor_row     <= 6'(cur_row);
      wrap_pending   <= hang;
      cursor_visible <= shown;
      cell_char      <= is_read ? rdata[7:0] : 8'd0;
      cell_inverse   <= is_read ? rdata[8] : 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vt102_text_cell_engine.sv
// ----------------------------------------------------------------------------
// vt102_text_cell_engine
// Terminal text cell store with cursor, deferred wrap, saved cursor, scroll
// region and cursor blink, driven by one command per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on the result ports with done high for exactly one cycle and must
// be taken then, as the receiver cannot stall. A request is planned, then
// runs the cell sweeps it needs: a blanked cell is written directly and a
// copied cell is read then written (on the single store port pair), so a
// scroll of R region rows by one line copies R-1 rows and blanks one. After
// reset and after each write of CFG_COLS or CFG_ROWS the store is cleared,
// one cell a cycle, over all rows and columns in use, with busy high.
`default_nettype none

module vt102_text_cell_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [4:0]        kind,
  input  wire logic [7:0]        glyph,
  input  wire logic              inverse,
  input  wire logic [7:0]        count,
  input  wire logic signed [7:0] column,
  input  wire logic signed [7:0] row,
  input  wire logic signed [7:0] bottom_row,
  input  wire logic [1:0]        erase_mode,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output logic                   done,
  output logic [6:0]             cursor_column,
  output logic [5:0]             cursor_row,
  output logic                   wrap_pending,
  output logic                   cursor_visible,
  output logic [7:0]             cell_char,
  output logic                   cell_inverse
);

  vtc_pkg::cmd_t  cmd;
  vtc_pkg::stat_t st;

  // sequencer
  vtc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // state, planning and cell store
  vtc_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .glyph          (glyph),
    .inverse        (inverse),
    .count          (count),
    .column         (column),
    .row            (row),
    .bottom_row     (bottom_row),
    .erase_mode     (erase_mode),
    .done           (done),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .wrap_pending   (wrap_pending),
    .cursor_visible (cursor_visible),
    .cell_char      (cell_char),
    .cell_inverse   (cell_inverse)
  );

endmodule

`default_nettype wire
